// ===== rtl/core/lvmf_pkg.sv =====
// ---------------------------------------------------------------------------
// lvmf_pkg
// Types and fixed constants of the learned value match filter.
// ---------------------------------------------------------------------------
package lvmf_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 16;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int CFG_W   = 9;
    localparam int HIT_W   = 9;
    localparam int TOTAL_W = 17;

    typedef logic        [1:0]         t_op;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic        [INDEX_W-1:0] t_index;
    typedef logic        [COUNT_W-1:0] t_count;
    typedef logic        [CFG_W-1:0]   t_cfg_data;
    typedef logic                      t_cfg_index;
    typedef logic        [HIT_W-1:0]   t_hits;
    typedef logic        [TOTAL_W-1:0] t_total;

    // Operation codes carried by an input word.
    localparam t_op OP_MATCH  = 2'd0;
    localparam t_op OP_LOAD   = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;
    localparam t_op OP_RSTCNT = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_index CFG_TABLE_SIZE    = 1'b0;
    localparam t_cfg_index CFG_MAX_PER_ENTRY = 1'b1;

    // Reset and special values.
    localparam int        DEFAULT_SIZE      = 12;
    localparam t_cfg_data TABLE_SIZE_RST    = 9'd12;
    localparam t_cfg_data MAX_PER_ENTRY_RST = 9'd2;
    localparam t_value    RESET_VALUE       = -16'sd1;
    localparam t_value    CLEAR_VALUE       = -16'sd9999;
    localparam t_total    TOTAL_MAX         = 17'h1FFFF;

endpackage

// ===== rtl/core/learned_value_match_filter.sv =====
// ---------------------------------------------------------------------------
// learned_value_match_filter
// Table of learned or loaded values with per-entry hit counters. Match words
// walk the filled entries (all active ones once complete) one entry per cycle.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_ready    operation, value, index, last
//  result    out        o_out_valid / i_out_ready  pass_count, no_match,
//                                                  fill_changed, fill_level,
//                                                  full_res, learning
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
//  A match word walks the scanned entries through the memories, one read per
//  cycle, and then takes the learn step. A load writes at most one entry, a
//  clear writes its new size in entries and a counter reset the active size,
//  one memory write per entry. After reset a clearing pass writes all
//  MAX_ENTRIES entries while o_in_ready stays low. One word is worked on at
//  a time; the next is taken while a result waits, but a word that finishes
//  before the output register is free stalls the input.
// ---------------------------------------------------------------------------
module learned_value_match_filter #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lvmf_pkg::t_op         i_operation,
    input  lvmf_pkg::t_value      i_value,
    input  lvmf_pkg::t_index      i_index,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lvmf_pkg::t_count      o_pass_count,
    output logic                  o_no_match,
    output logic                  o_fill_changed,
    output lvmf_pkg::t_count      o_fill_level,
    output logic                  o_full_res,
    output logic                  o_learning,
    input  logic                  i_cfg_we,
    input  lvmf_pkg::t_cfg_index  i_cfg_index,
    input  lvmf_pkg::t_cfg_data   i_cfg_data
);
    import lvmf_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int QW = CW + CFG_W;
    localparam int PW = (QW > TOTAL_W) ? QW : TOTAL_W;
    localparam logic [CW-1:0] MAX_CNT    = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] LAST_CNT   = CW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] RESET_SIZE =
        CW'((DEFAULT_SIZE > MAX_ENTRIES) ? MAX_ENTRIES : DEFAULT_SIZE);

    // Sequencer states.
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LEARN  = 3'd3;
    localparam logic [2:0] S_LOAD   = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_RSTCNT = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // Control and configuration state.
    logic [2:0]     r_state;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  r_scan_len;
    logic           r_rd_vld;
    logic [AW-1:0]  r_rd_addr;
    t_cfg_data      r_table_size;
    t_cfg_data      r_max_per_entry;
    logic [CW-1:0]  r_active;
    logic [CW-1:0]  r_filled;
    logic           r_complete;
    t_total         r_total;
    logic [QW-1:0]  r_prod;

    // Word being worked on.
    t_op            r_op;
    t_value         r_val;
    t_index         r_idx;
    logic           r_last;
    logic [CW-1:0]  r_passes;
    logic           r_found;
    logic           r_fillchg;

    // Output register.
    logic           r_out_valid;
    t_count         r_pass_count;
    logic           r_no_match;
    logic           r_fill_changed;
    t_count         r_fill_level;
    logic           r_full_res;
    logic           r_learning;

    // Table memories.
    t_value         mem_val  [MAX_ENTRIES];
    t_hits          mem_hits [MAX_ENTRIES];
    t_value         r_rd_val;
    t_hits          r_rd_hits;

    logic           w_we_val;
    logic           w_we_hits;
    logic [AW-1:0]  w_waddr;
    t_value         w_wval;
    t_hits          w_whits;

    t_hits          w_quota;
    logic           w_hit;
    logic           w_pass;
    logic           w_learn;
    logic [CW-1:0]  n_filled;
    t_total         n_total;
    t_count         w_idx_plus;
    logic [CW-1:0]  w_load_size;
    t_cfg_data      w_tsize;
    logic [CW-1:0]  w_clear_size;
    logic           w_idx_ok;
    logic           w_is_match;
    logic [QW-1:0]  w_passes_ext;
    logic [QW-1:0]  w_filled_ext;

    // Quota, compare of the entry read last cycle, and saturated sizes.
    always_comb begin
        w_quota      = (r_max_per_entry != '0) ? t_hits'(r_max_per_entry) : t_hits'(1);
        w_hit        = r_rd_vld && (r_rd_val == r_val);
        w_pass       = w_hit && (r_rd_hits < w_quota);
        w_learn      = !r_complete && (r_active > r_filled) && !r_found &&
                       (r_filled < MAX_CNT);
        n_filled     = w_learn ? r_filled + 1'b1 : r_filled;
        n_total      = (r_total == TOTAL_MAX) ? r_total : r_total + 1'b1;
        w_idx_plus   = {1'b0, r_idx} + 9'd1;
        w_load_size  = (32'(w_idx_plus) > MAX_ENTRIES) ? MAX_CNT : CW'(w_idx_plus);
        w_tsize      = (r_table_size != '0) ? r_table_size : TABLE_SIZE_RST;
        w_clear_size = (32'(w_tsize) > MAX_ENTRIES) ? MAX_CNT : CW'(w_tsize);
        w_idx_ok     = 32'(r_idx) < MAX_ENTRIES;
        w_is_match   = (r_op == OP_MATCH);
        w_passes_ext = QW'(r_passes);
        w_filled_ext = QW'(r_filled);
    end

    // Memory write port, selected by the sequencer state.
    always_comb begin
        w_we_val  = 1'b0;
        w_we_hits = 1'b0;
        w_waddr   = r_cnt[AW-1:0];
        w_wval    = r_val;
        w_whits   = '0;
        case (r_state)
            S_INIT: begin
                w_we_val  = 1'b1;
                w_we_hits = 1'b1;
                w_wval    = RESET_VALUE;
            end
            S_SCAN: begin
                w_we_hits = w_pass;
                w_waddr   = r_rd_addr;
                w_whits   = r_rd_hits + 1'b1;
            end
            S_LEARN: begin
                w_we_val  = w_learn;
                w_we_hits = w_learn;
                w_waddr   = r_filled[AW-1:0];
                w_whits   = t_hits'(1);
            end
            S_LOAD: begin
                w_we_val  = w_idx_ok;
                w_we_hits = w_idx_ok;
                w_waddr   = AW'(r_idx);
            end
            S_CLEAR: begin
                w_we_val  = 1'b1;
                w_we_hits = 1'b1;
                w_wval    = CLEAR_VALUE;
            end
            S_RSTCNT: begin
                w_we_hits = 1'b1;
            end
            default: begin
                w_we_val  = 1'b0;
                w_we_hits = 1'b0;
            end
        endcase
    end

    // Value and hit memories, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we_val) begin
            mem_val[w_waddr] <= w_wval;
        end
        r_rd_val <= mem_val[r_cnt[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_hits) begin
            mem_hits[w_waddr] <= w_whits;
        end
        r_rd_hits <= mem_hits[r_cnt[AW-1:0]];
    end

    // Full threshold, refreshed every cycle from the active size and quota.
    always_ff @(posedge i_clk) begin
        r_prod <= QW'(r_active) * QW'(r_max_per_entry);
    end

    // Sequencer and table state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_INIT;
            r_cnt           <= '0;
            r_rd_vld        <= 1'b0;
            r_table_size    <= TABLE_SIZE_RST;
            r_max_per_entry <= MAX_PER_ENTRY_RST;
            r_active        <= RESET_SIZE;
            r_filled        <= '0;
            r_complete      <= 1'b0;
            r_total         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TABLE_SIZE:    r_table_size    <= i_cfg_data;
                    CFG_MAX_PER_ENTRY: r_max_per_entry <= i_cfg_data;
                    default:           r_table_size    <= r_table_size;
                endcase
            end

            // The result word leaves; a new one from the last step refills it.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_INIT: begin
                    if (r_cnt == LAST_CNT) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end

                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op      <= i_operation;
                        r_val     <= i_value;
                        r_idx     <= i_index;
                        r_last    <= i_last;
                        r_passes  <= '0;
                        r_found   <= 1'b0;
                        r_fillchg <= 1'b0;
                        r_cnt     <= '0;
                        r_rd_vld  <= 1'b0;
                        case (i_operation)
                            OP_MATCH: begin
                                r_scan_len <= r_complete ? r_active : r_filled;
                                r_state    <= S_SCAN;
                            end
                            OP_LOAD: begin
                                r_state <= S_LOAD;
                            end
                            OP_CLEAR: begin
                                r_scan_len <= w_clear_size;
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                                r_scan_len <= r_active;
                                r_state    <= S_RSTCNT;
                            end
                        endcase
                    end
                end

                // Issue one read per cycle and score the entry read last cycle.
                S_SCAN: begin
                    r_rd_vld  <= (r_cnt < r_scan_len);
                    r_rd_addr <= r_cnt[AW-1:0];
                    if (r_cnt < r_scan_len) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (w_hit) begin
                        r_found <= 1'b1;
                    end
                    if (w_pass) begin
                        r_passes <= r_passes + 1'b1;
                        r_total  <= n_total;
                    end
                    if (!(r_cnt < r_scan_len) && !r_rd_vld) begin
                        r_state <= S_LEARN;
                    end
                end

                // Append an unmatched value while learning.
                S_LEARN: begin
                    if (!r_complete) begin
                        if (w_learn) begin
                            r_filled  <= n_filled;
                            r_passes  <= r_passes + 1'b1;
                            r_total   <= n_total;
                            r_found   <= 1'b1;
                            r_fillchg <= 1'b1;
                        end
                        if (n_filled == r_active) begin
                            r_complete <= 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end

                S_LOAD: begin
                    if (r_last) begin
                        r_active   <= w_load_size;
                        r_filled   <= w_load_size;
                        r_complete <= 1'b1;
                        r_total    <= '0;
                        r_fillchg  <= 1'b1;
                    end
                    r_state <= S_DONE;
                end

                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_scan_len - 1'b1) begin
                        r_active   <= r_scan_len;
                        r_complete <= 1'b0;
                        r_filled   <= '0;
                        r_total    <= '0;
                        r_state    <= S_DONE;
                    end
                end

                S_RSTCNT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_scan_len - 1'b1) begin
                        r_filled <= r_complete ? r_active : '0;
                        r_total  <= '0;
                        r_state  <= S_DONE;
                    end
                end

                // Hand the result word to the output register once it is free.
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload, loaded together with the valid flag.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_pass_count   <= w_passes_ext[COUNT_W-1:0];
            r_no_match     <= w_is_match && !r_found;
            r_fill_changed <= r_fillchg;
            r_fill_level   <= w_filled_ext[COUNT_W-1:0];
            r_full_res     <= w_is_match && (PW'(r_total) >= PW'(r_prod));
            r_learning     <= !r_complete;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_pass_count   = r_pass_count;
    assign o_no_match     = r_no_match;
    assign o_fill_changed = r_fill_changed;
    assign o_fill_level   = r_fill_level;
    assign o_full_res     = r_full_res;
    assign o_learning     = r_learning;

endmodule
